FILE: rtl/stt_pkg.sv
`timescale 1ns / 1ps
// Shared types, token codes and keyword table of the source text tokenizer.
package stt_pkg;

  localparam int POS_BITS   = 32;
  localparam int LEN_BITS   = 16;
  localparam int KIND_BITS  = 6;
  localparam int PFX_DEPTH  = 6;
  localparam int NUM_KW     = 16;
  localparam int SLOTS      = 4;
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);
  localparam int KWLEN_BITS = 3;

  typedef logic [POS_BITS-1:0]          stt_pos_t;
  typedef logic [LEN_BITS-1:0]          stt_len_t;
  typedef logic [KIND_BITS-1:0]         stt_kind_t;
  typedef logic [0:PFX_DEPTH-1][7:0]    stt_pfx_t;
  typedef logic [KWLEN_BITS-1:0]        stt_kwlen_t;

  // One token on its way from the front end to the output stage.
  typedef struct packed {
    stt_kind_t kind;
    stt_pos_t  start;
    stt_len_t  length;
    logic      last;
    stt_pfx_t  prefix;
  } stt_tok_t;

  localparam stt_len_t LEN_MAX = '1;
  localparam stt_len_t LEN_ONE = stt_len_t'(1);
  localparam stt_len_t LEN_TWO = stt_len_t'(2);

  // Token kinds
  localparam stt_kind_t KIND_NONE        = 6'h00;
  localparam stt_kind_t KIND_IDENT       = 6'h01;
  localparam stt_kind_t KIND_NUMBER      = 6'h02;
  localparam stt_kind_t KIND_LINE_CMT    = 6'h03;
  localparam stt_kind_t KIND_BLOCK_OPEN  = 6'h04;
  localparam stt_kind_t KIND_BLOCK_CLOSE = 6'h05;
  localparam stt_kind_t KIND_LPAREN      = 6'h06;
  localparam stt_kind_t KIND_RPAREN      = 6'h07;
  localparam stt_kind_t KIND_LBRACE      = 6'h08;
  localparam stt_kind_t KIND_RBRACE      = 6'h09;
  localparam stt_kind_t KIND_LESS        = 6'h0A;
  localparam stt_kind_t KIND_GREATER     = 6'h0B;
  localparam stt_kind_t KIND_LBRACKET    = 6'h0C;
  localparam stt_kind_t KIND_RBRACKET    = 6'h0D;
  localparam stt_kind_t KIND_SQUOTE      = 6'h0E;
  localparam stt_kind_t KIND_DQUOTE      = 6'h0F;
  localparam stt_kind_t KIND_ARROW       = 6'h18;
  localparam stt_kind_t KIND_DOT         = 6'h21;
  localparam stt_kind_t KIND_SEMI        = 6'h22;
  localparam stt_kind_t KIND_COLON       = 6'h23;
  localparam stt_kind_t KIND_COMMA       = 6'h24;
  localparam stt_kind_t KIND_NEWLINE     = 6'h25;
  localparam stt_kind_t KIND_PLUS        = 6'h28;
  localparam stt_kind_t KIND_MINUS       = 6'h29;
  localparam stt_kind_t KIND_STAR        = 6'h2A;
  localparam stt_kind_t KIND_SLASH       = 6'h2B;
  localparam stt_kind_t KIND_PERCENT     = 6'h2C;
  localparam stt_kind_t KIND_EQUAL       = 6'h2D;

  // Source characters
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LESS     = 8'h3C;
  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_GREATER  = 8'h3E;
  localparam logic [7:0] CH_UPPER_LO = 8'h41;
  localparam logic [7:0] CH_UPPER_HI = 8'h5A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_LOWER_LO = 8'h61;
  localparam logic [7:0] CH_LOWER_HI = 8'h7A;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;

  // Keywords, first character in prefix slot 0
  localparam stt_pfx_t KW_TEXT [NUM_KW] = '{
    {"def", 24'h0}, {"set", 24'h0}, {"del", 24'h0}, {"req", 24'h0},
    {"call", 16'h0}, "method", {"class", 8'h0}, "return",
    {"int", 24'h0}, {"float", 8'h0}, "string", {"ref", 24'h0},
    {"bool", 16'h0}, {"array", 8'h0}, {"map", 24'h0}, {"auto", 16'h0}
  };

  localparam stt_kwlen_t KW_LEN [NUM_KW] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd6, 3'd5, 3'd6,
    3'd3, 3'd5, 3'd6, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4
  };

  localparam stt_kind_t KW_CODE [NUM_KW] = '{
    6'h10, 6'h11, 6'h12, 6'h13, 6'h14, 6'h15, 6'h16, 6'h17,
    6'h19, 6'h1A, 6'h1B, 6'h1C, 6'h1D, 6'h1E, 6'h1F, 6'h20
  };

endpackage

FILE: rtl/stt_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for text bytes in and tokens out.
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface stt_token_if;
  import stt_pkg::*;
  logic      valid;
  logic      ready;
  stt_kind_t token_kind;
  stt_pos_t  token_start;
  stt_len_t  token_length;
  logic      run_last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output run_last, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input run_last, output ready);
endinterface

FILE: rtl/stt_front.sv
`timescale 1ns / 1ps
// Front end: takes bytes, tracks the pending word and lists the tokens of each item.
module stt_front (
  input  logic             clk,
  input  logic             rst_n,
  stt_byte_if.sink         in_bytes,
  output logic             push_valid,
  output stt_pkg::stt_tok_t push_tok,
  input  logic             push_ready
);
  import stt_pkg::*;

  typedef struct packed {
    logic      sym;
    logic      space;
    logic      pair;
    stt_kind_t kind;
  } stt_cls_t;

  typedef struct packed {
    stt_pos_t start;
    stt_len_t len;
    logic     digits;
    logic     ident;
    stt_pfx_t pfx;
  } stt_word_t;

  localparam stt_word_t WORD_CLEAR = '{start: '0, len: '0, digits: 1'b1, ident: 1'b1,
                                       pfx: '0};

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c == CH_UNDER) || ((c >= CH_UPPER_LO) && (c <= CH_UPPER_HI)) ||
           ((c >= CH_LOWER_LO) && (c <= CH_LOWER_HI));
  endfunction

  function automatic stt_cls_t classify(logic [7:0] c, logic has_la, logic [7:0] la);
    stt_cls_t r;
    r = '{sym: 1'b1, space: 1'b0, pair: 1'b0, kind: KIND_NONE};
    unique case (c)
      CH_SLASH: begin
        if (has_la && la == CH_SLASH) begin
          r.kind = KIND_LINE_CMT;
          r.pair = 1'b1;
        end else if (has_la && la == CH_STAR) begin
          r.kind = KIND_BLOCK_OPEN;
          r.pair = 1'b1;
        end else begin
          r.kind = KIND_SLASH;
        end
      end
      CH_STAR: begin
        if (has_la && la == CH_SLASH) begin
          r.kind = KIND_BLOCK_CLOSE;
          r.pair = 1'b1;
        end else begin
          r.kind = KIND_STAR;
        end
      end
      CH_MINUS: begin
        if (has_la && la == CH_GREATER) begin
          r.kind = KIND_ARROW;
          r.pair = 1'b1;
        end else begin
          r.kind = KIND_MINUS;
        end
      end
      CH_LPAREN:   r.kind = KIND_LPAREN;
      CH_RPAREN:   r.kind = KIND_RPAREN;
      CH_LBRACE:   r.kind = KIND_LBRACE;
      CH_RBRACE:   r.kind = KIND_RBRACE;
      CH_LESS:     r.kind = KIND_LESS;
      CH_GREATER:  r.kind = KIND_GREATER;
      CH_LBRACKET: r.kind = KIND_LBRACKET;
      CH_RBRACKET: r.kind = KIND_RBRACKET;
      CH_SQUOTE:   r.kind = KIND_SQUOTE;
      CH_DQUOTE:   r.kind = KIND_DQUOTE;
      CH_DOT:      r.kind = KIND_DOT;
      CH_SEMI:     r.kind = KIND_SEMI;
      CH_COLON:    r.kind = KIND_COLON;
      CH_COMMA:    r.kind = KIND_COMMA;
      CH_NEWLINE:  r.kind = KIND_NEWLINE;
      CH_PLUS:     r.kind = KIND_PLUS;
      CH_PERCENT:  r.kind = KIND_PERCENT;
      CH_EQUAL:    r.kind = KIND_EQUAL;
      CH_SPACE, CH_TAB: begin
        r.sym   = 1'b0;
        r.space = 1'b1;
      end
      default:     r.sym = 1'b0;
    endcase
    return r;
  endfunction

  function automatic stt_word_t append_byte(stt_word_t w, logic [7:0] c, stt_pos_t pos);
    stt_word_t r;
    r = w;
    if (w.len == '0) begin
      r.start = pos;
      r.ident = is_alpha(c);
    end else begin
      r.ident = w.ident && (is_alpha(c) || is_digit(c));
    end
    r.digits = w.digits && is_digit(c);
    for (int i = 0; i < PFX_DEPTH; i++) begin
      if (w.len == stt_len_t'(i)) r.pfx[i] = c;
    end
    if (w.len != LEN_MAX) r.len = w.len + 1'b1;
    return r;
  endfunction

  function automatic logic word_ok(stt_word_t w);
    return (w.len != '0) && (w.digits || w.ident);
  endfunction

  function automatic stt_tok_t word_tok(stt_word_t w);
    stt_tok_t t;
    t.kind   = w.digits ? KIND_NUMBER : KIND_IDENT;
    t.start  = w.start;
    t.length = w.len;
    t.last   = 1'b0;
    t.prefix = w.pfx;
    return t;
  endfunction

  logic [7:0]     held_byte_r, held_byte_nxt;
  logic           held_valid_r, held_valid_nxt;
  logic           skip_next_r, skip_next_nxt;
  stt_pos_t       pos_r, pos_nxt;
  stt_word_t      word_r, word_nxt;
  stt_tok_t       pend_r [SLOTS];
  stt_tok_t       pend_nxt [SLOTS];
  logic [SLOTS-1:0] pend_vld_r, pend_vld_nxt;

  logic           acc;
  logic [7:0]     cur_byte;
  logic           cur_end;
  stt_pos_t       held_pos;
  stt_cls_t       cls_a, cls_b;
  logic           act_a, act_b, a_word, a_flush, b_word, skip1;
  stt_word_t      w1, w2;
  stt_tok_t       new_tok [SLOTS];
  logic [SLOTS-1:0] new_vld;
  logic [SLOT_BITS-1:0] head_idx;
  logic           one_left, pushed;

  assign cur_byte = in_bytes.text_byte;
  assign cur_end  = in_bytes.text_end;
  assign held_pos = pos_r - 1'b1;

  // Pending slots drain one per cycle unless stalled; take an item as the last goes.
  assign one_left       = (pend_vld_r & (pend_vld_r - 1'b1)) == '0;
  assign in_bytes.ready = one_left && ((pend_vld_r == '0) || push_ready);
  assign acc            = in_bytes.valid && in_bytes.ready;

  always_comb begin
    cls_a   = classify(held_byte_r, 1'b1, cur_byte);
    cls_b   = classify(cur_byte, 1'b0, 8'h00);
    act_a   = held_valid_r && !skip_next_r;
    a_word  = act_a && !cls_a.sym && !cls_a.space;
    a_flush = act_a && (cls_a.sym || cls_a.space);
    skip1   = act_a && cls_a.sym && cls_a.pair;

    if (a_word) begin
      w1 = append_byte(word_r, held_byte_r, held_pos);
    end else if (a_flush) begin
      w1 = WORD_CLEAR;
    end else begin
      w1 = word_r;
    end

    // The final byte has no lookahead; flush whatever word is left after it.
    act_b  = cur_end && !skip1;
    b_word = act_b && !cls_b.sym && !cls_b.space;
    w2     = b_word ? append_byte(w1, cur_byte, pos_r) : w1;

    new_tok[0] = word_tok(word_r);
    new_vld[0] = a_flush && word_ok(word_r);

    new_tok[1].kind   = cls_a.kind;
    new_tok[1].start  = held_pos;
    new_tok[1].length = cls_a.pair ? LEN_TWO : LEN_ONE;
    new_tok[1].last   = 1'b0;
    new_tok[1].prefix = '0;
    new_vld[1]        = act_a && cls_a.sym;

    new_tok[2] = word_tok(w2);
    new_vld[2] = cur_end && word_ok(w2);

    new_tok[3].kind   = cls_b.kind;
    new_tok[3].start  = pos_r;
    new_tok[3].length = LEN_ONE;
    new_tok[3].last   = 1'b0;
    new_tok[3].prefix = '0;
    new_vld[3]        = act_b && cls_b.sym;

    // Mark the last token that this item causes.
    for (int i = 0; i < SLOTS; i++) begin
      new_tok[i].last = new_vld[i] && ((new_vld >> (i + 1)) == '0);
    end
  end

  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    skip_next_nxt  = skip_next_r;
    pos_nxt        = pos_r;
    word_nxt       = word_r;
    if (acc) begin
      if (cur_end) begin
        held_byte_nxt  = 8'h00;
        held_valid_nxt = 1'b0;
        skip_next_nxt  = 1'b0;
        pos_nxt        = '0;
        word_nxt       = WORD_CLEAR;
      end else begin
        held_byte_nxt  = cur_byte;
        held_valid_nxt = 1'b1;
        skip_next_nxt  = skip1;
        pos_nxt        = pos_r + 1'b1;
        word_nxt       = w1;
      end
    end
  end

  always_comb begin
    head_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pend_vld_r[i]) head_idx = SLOT_BITS'(i);
    end
  end

  assign push_valid = pend_vld_r != '0;
  assign push_tok   = pend_r[head_idx];
  assign pushed     = push_valid && push_ready;

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    if (acc) begin
      pend_vld_nxt = new_vld;
      pend_nxt     = new_tok;
    end else if (pushed) begin
      pend_vld_nxt[head_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r  <= 8'h00;
      held_valid_r <= 1'b0;
      skip_next_r  <= 1'b0;
      pos_r        <= '0;
      word_r       <= WORD_CLEAR;
      pend_vld_r   <= '0;
    end else begin
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      skip_next_r  <= skip_next_nxt;
      pos_r        <= pos_nxt;
      word_r       <= word_nxt;
      pend_vld_r   <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && cur_end) |=> (!held_valid_r && !skip_next_r && pos_r == '0))
    else $error("state not back at start after final byte");

  a_skip_held: assert property (@(posedge clk) disable iff (!rst_n)
    skip_next_r |-> held_valid_r)
    else $error("pair skip pending with no held byte");

  a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
    !held_valid_r |-> (word_r.len == '0))
    else $error("pending word with no held byte");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((pend_vld_r != '0) && !push_ready) |=> (pend_vld_r == $past(pend_vld_r)))
    else $error("pending tokens changed while queue full");

endmodule

FILE: rtl/stt_queue.sv
`timescale 1ns / 1ps
// Token queue between the front end and the output stage.
module stt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  stt_pkg::stt_tok_t push_tok,
  output logic              push_ready,
  output logic              pop_valid,
  output stt_pkg::stt_tok_t pop_tok,
  input  logic              pop
);
  import stt_pkg::*;

  stt_tok_t               mem_r [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                   do_push, do_pop;

  assign push_ready = cnt_r != QCNT_BITS'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_tok    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_tok;
  end

endmodule

FILE: rtl/stt_back.sv
`timescale 1ns / 1ps
// Output stage: resolves keywords and holds the token on the result channel.
module stt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  stt_pkg::stt_tok_t q_tok,
  output logic              q_pop,
  stt_token_if.source       out_tokens
);
  import stt_pkg::*;

  function automatic logic kw_hit(stt_pfx_t a, stt_pfx_t b, stt_kwlen_t n);
    logic m;
    m = 1'b1;
    for (int j = 0; j < PFX_DEPTH; j++) begin
      if ((j < int'(n)) && (a[j] != b[j])) m = 1'b0;
    end
    return m;
  endfunction

  function automatic stt_kind_t resolve(stt_tok_t t);
    stt_kind_t k;
    k = t.kind;
    if (t.kind == KIND_IDENT) begin
      for (int i = 0; i < NUM_KW; i++) begin
        if ((t.length == stt_len_t'(KW_LEN[i])) && kw_hit(t.prefix, KW_TEXT[i], KW_LEN[i]))
          k = KW_CODE[i];
      end
    end
    return k;
  endfunction

  logic      out_vld_r, out_vld_nxt;
  stt_kind_t kind_r;
  stt_pos_t  start_r;
  stt_len_t  length_r;
  logic      last_r;

  // Load a new token when the output register is empty or being taken.
  assign q_pop = q_valid && (!out_vld_r || out_tokens.ready);

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (q_pop) begin
      out_vld_nxt = 1'b1;
    end else if (out_tokens.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r   <= resolve(q_tok);
      start_r  <= q_tok.start;
      length_r <= q_tok.length;
      last_r   <= q_tok.last;
    end
  end

  assign out_tokens.valid        = out_vld_r;
  assign out_tokens.token_kind   = kind_r;
  assign out_tokens.token_start  = start_r;
  assign out_tokens.token_length = length_r;
  assign out_tokens.run_last     = last_r;

endmodule

FILE: rtl/source_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// Top level of the source text tokenizer: front end, token queue, output stage.
//
// Bytes enter on in_bytes, one per handshake; each byte is decided once the next
// byte arrives (or at once when text_end is set), and the tokens it causes leave
// on out_tokens as kind, start offset and saturating length, with run_last on the
// last token of that byte. The front end lists all tokens of a byte at once and
// pushes them into a four-entry queue one per cycle while it has room, so while
// the queue has room a byte that causes zero or one token is taken every cycle
// and one that causes more holds the input until only its last token is left;
// the result channel carries one token per cycle while ready is high, setting
// the sustained rate. Tokens pass the pending slots, queue and output register.
// Offsets restart at zero after text_end; the output stage resolves keywords.
module source_text_tokenizer_unit (
  input  logic         clk,
  input  logic         rst_n,
  stt_byte_if.sink     in_bytes,
  stt_token_if.source  out_tokens
);
  import stt_pkg::*;

  logic     push_valid, push_ready;
  stt_tok_t push_tok;
  logic     q_valid, q_pop;
  stt_tok_t q_tok;

  stt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bytes   (in_bytes),
    .push_valid (push_valid),
    .push_tok   (push_tok),
    .push_ready (push_ready)
  );

  stt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_tok   (push_tok),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_tok    (q_tok),
    .pop        (q_pop)
  );

  stt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_tok      (q_tok),
    .q_pop      (q_pop),
    .out_tokens (out_tokens)
  );

endmodule
